// File: hdl/mfl_pkg.sv
// shared constants, types and register map for the message flood limiter
// no dependencies; used by every module and interface of the block
package mfl_pkg;

	localparam int RING_DEPTH = 16;

	localparam int STAMP_W = 32;
	localparam int WAIT_W  = 32;
	localparam int MAX_W   = 5;
	localparam int WIN_W   = 16;
	localparam int LOCK_W  = 16;

	localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int LIM_W = (CNT_W > MAX_W) ? CNT_W : MAX_W;
	localparam int SUM_W = PTR_W + 1;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_MAX_MESSAGES  = 2'd0;
	localparam reg_idx_t REG_WINDOW_FRAMES = 2'd1;
	localparam reg_idx_t REG_LOCK_FRAMES   = 2'd2;

	localparam logic [MAX_W-1:0]  MAX_MESSAGES_RST  = MAX_W'(4);
	localparam logic [WIN_W-1:0]  WINDOW_FRAMES_RST = WIN_W'(40);
	localparam logic [LOCK_W-1:0] LOCK_FRAMES_RST   = LOCK_W'(100);

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_LOCKED = 2'd1,
		VERDICT_FLOOD  = 2'd2
	} verdict_t;

	typedef struct packed {
		logic [MAX_W-1:0]  max_messages;
		logic [WIN_W-1:0]  window_frames;
		logic [LOCK_W-1:0] lock_frames;
	} cfg_t;

endpackage

// File: hdl/mfl_attempt_if.sv
// channel for message attempts: valid/ready handshake and the frame stamp
// depends on mfl_pkg for the stamp width
interface mfl_attempt_if;
	logic                        valid;
	logic                        ready;
	logic [mfl_pkg::STAMP_W-1:0] frame_now;

	modport source (output valid, output frame_now, input ready);
	modport sink (input valid, input frame_now, output ready);
endinterface

// File: hdl/mfl_result_if.sv
// channel for limiter decisions: valid/ready handshake, verdict and wait count
// depends on mfl_pkg for the verdict type and wait width
interface mfl_result_if;
	logic                       valid;
	logic                       ready;
	mfl_pkg::verdict_t          verdict;
	logic [mfl_pkg::WAIT_W-1:0] wait_frames;

	modport source (output valid, output verdict, output wait_frames, input ready);
	modport sink (input valid, input verdict, input wait_frames, output ready);
endinterface

// File: hdl/mfl_cfg_regs.sv
// apb configuration registers: limit, window length and lockout length
// depends on mfl_pkg for the register map, reset values and cfg_t
module mfl_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mfl_pkg::ADDR_W-1:0]  paddr,
	input  logic [mfl_pkg::DATA_W-1:0]  pwdata,
	output logic [mfl_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output mfl_pkg::cfg_t               cfg
);
	import mfl_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_messages  <= MAX_MESSAGES_RST;
			cfg_q.window_frames <= WINDOW_FRAMES_RST;
			cfg_q.lock_frames   <= LOCK_FRAMES_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAX_MESSAGES:  cfg_q.max_messages  <= pwdata[MAX_W-1:0];
				REG_WINDOW_FRAMES: cfg_q.window_frames <= pwdata[WIN_W-1:0];
				REG_LOCK_FRAMES:   cfg_q.lock_frames   <= pwdata[LOCK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_MESSAGES:  prdata = DATA_W'(cfg_q.max_messages);
			REG_WINDOW_FRAMES: prdata = DATA_W'(cfg_q.window_frames);
			REG_LOCK_FRAMES:   prdata = DATA_W'(cfg_q.lock_frames);
			default:           prdata = '0;
		endcase
	end
endmodule

// File: hdl/mfl_decide.sv
// decision logic and limiter state: stamp ring, pointer, fill count, lockout end
// depends on mfl_pkg; decides one attempt per cycle and updates state on fire
module mfl_decide (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         fire,
	input  logic [mfl_pkg::STAMP_W-1:0]  frame_now,
	input  mfl_pkg::cfg_t                cfg,
	output mfl_pkg::verdict_t            verdict,
	output logic [mfl_pkg::WAIT_W-1:0]   wait_frames
);
	import mfl_pkg::*;

	logic [STAMP_W-1:0] ring_q [RING_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic [STAMP_W-1:0] lock_until_q;

	logic [LIM_W-1:0]   max_ext;
	logic [LIM_W-1:0]   limit;
	logic [SUM_W-1:0]   slot_sum;
	logic [PTR_W-1:0]   slot;
	logic [STAMP_W-1:0] age;
	logic               disabled;
	logic               locked;
	logic               enough;
	logic               flood;
	logic               do_push;
	logic               do_lock;

	always_comb begin
		max_ext  = LIM_W'(cfg.max_messages);
		limit    = (max_ext > LIM_W'(RING_DEPTH)) ? LIM_W'(RING_DEPTH) : max_ext;
		disabled = (cfg.max_messages == '0);
		locked   = (frame_now < lock_until_q);
		enough   = (LIM_W'(count_q) >= limit);
		// oldest stamp that still counts toward the limit
		slot_sum = SUM_W'(wr_ptr_q) + SUM_W'(RING_DEPTH) - SUM_W'(limit);
		if (slot_sum >= SUM_W'(RING_DEPTH)) begin
			slot_sum = slot_sum - SUM_W'(RING_DEPTH);
		end
		slot  = slot_sum[PTR_W-1:0];
		age   = frame_now - ring_q[slot];
		flood = enough && (age < STAMP_W'(cfg.window_frames));

		do_push = 1'b0;
		do_lock = 1'b0;
		verdict     = VERDICT_ACCEPT;
		wait_frames = '0;
		if (!disabled) begin
			if (locked) begin
				verdict     = VERDICT_LOCKED;
				wait_frames = lock_until_q - frame_now;
			end else if (flood) begin
				verdict     = VERDICT_FLOOD;
				wait_frames = WAIT_W'(cfg.lock_frames);
				do_lock     = 1'b1;
			end else begin
				do_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_push) begin
			ring_q[wr_ptr_q] <= frame_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q     <= '0;
			count_q      <= '0;
			lock_until_q <= '0;
		end else if (fire) begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(RING_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
				if (count_q != CNT_W'(RING_DEPTH)) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (do_lock) begin
				lock_until_q <= frame_now + STAMP_W'(cfg.lock_frames);
			end
		end
	end
endmodule

// File: hdl/message_flood_limiter.sv
// message flood limiter: one attempt per cycle while the result side keeps up; registered result
// result path: input register, then decision logic into the result register
// throughput: one attempt every cycle; limited only by result-side backpressure
// reset: arst_n clears handshake state, ring pointer, fill count and lockout end,
// and loads the register defaults; the stamp ring itself is never cleared
// and needs no clearing pass, since only stored stamps are ever compared
module message_flood_limiter (
	input  logic                        clk,
	input  logic                        arst_n,
	mfl_attempt_if.sink                 attempt,
	mfl_result_if.source                outcome,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mfl_pkg::ADDR_W-1:0]  paddr,
	input  logic [mfl_pkg::DATA_W-1:0]  pwdata,
	output logic [mfl_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import mfl_pkg::*;

	cfg_t cfg;

	// stage 1: registered attempt
	logic               valid_s1;
	logic [STAMP_W-1:0] frame_now_s1;

	// stage 2: registered result, doubles as the output holding register
	logic               valid_s2;
	verdict_t           verdict_s2;
	logic [WAIT_W-1:0]  wait_frames_s2;

	// decision outputs for the attempt in stage 1
	verdict_t           verdict_d;
	logic [WAIT_W-1:0]  wait_frames_d;

	logic               advance;
	logic               in_xfer;

	// stage 1 moves on when the result slot is free or being drained this cycle
	assign advance = valid_s1 && (!valid_s2 || outcome.ready);
	assign attempt.ready = !valid_s1 || advance;
	assign in_xfer = attempt.valid && attempt.ready;

	mfl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// state updates land on the same edge as the result, so the next
	// attempt in stage 1 already sees the new ring, count and lockout
	mfl_decide u_decide (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (advance),
		.frame_now   (frame_now_s1),
		.cfg         (cfg),
		.verdict     (verdict_d),
		.wait_frames (wait_frames_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (outcome.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			frame_now_s1 <= attempt.frame_now;
		end
		if (advance) begin
			verdict_s2     <= verdict_d;
			wait_frames_s2 <= wait_frames_d;
		end
	end

	assign outcome.valid       = valid_s2;
	assign outcome.verdict     = verdict_s2;
	assign outcome.wait_frames = wait_frames_s2;
endmodule

// File: hdl/mfl_checker.sv
// port-level checks for the message flood limiter, bound to the top level
// depends on mfl_pkg for the verdict codes and field widths
module mfl_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  mfl_pkg::verdict_t           out_verdict,
	input  logic [mfl_pkg::WAIT_W-1:0]  out_wait_frames
);
	import mfl_pkg::*;

	// a stalled result holds still
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_verdict)
			&& $stable(out_wait_frames))
		else $error("result changed while stalled");

	// attempts are only held off when the result side is backed up
	a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("attempt side stalled without result backpressure");

	// accepted attempts report no wait
	a_accept_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_verdict == VERDICT_ACCEPT |-> out_wait_frames == '0)
		else $error("accepted attempt reports a wait");

	// a running lockout always has frames left
	a_locked_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_verdict == VERDICT_LOCKED |-> out_wait_frames != '0)
		else $error("lockout refusal with zero frames left");

	// after an attempt transfer, a ready result side keeps the input open
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready |-> in_ready)
		else $error("input stalled without backpressure");
endmodule

bind message_flood_limiter mfl_checker u_mfl_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (attempt.valid),
	.in_ready        (attempt.ready),
	.out_valid       (outcome.valid),
	.out_ready       (outcome.ready),
	.out_verdict     (outcome.verdict),
	.out_wait_frames (outcome.wait_frames)
);

// File: test/mfl_decision_checker.sv
// decision checker for the message flood limiter: predicts each verdict and compares results
// depends on mfl_pkg and on the attempt and result channel interfaces
module mfl_decision_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	mfl_attempt_if                     attempt,
	mfl_result_if                      outcome,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic                       pready,
	input  logic [mfl_pkg::ADDR_W-1:0] paddr,
	input  logic [mfl_pkg::DATA_W-1:0] pwdata,
	output int                         mismatches,
	output int                         outstanding
);
	import mfl_pkg::*;

	typedef struct packed {
		verdict_t            verdict;
		logic [WAIT_W-1:0]   wait_frames;
	} decision_t;

	// shadow of the limiter registers and state
	cfg_t               cfg;
	logic [STAMP_W-1:0] stamps [RING_DEPTH];
	logic [PTR_W-1:0]   next_slot;
	int                 stamp_fill;
	logic [STAMP_W-1:0] lock_end;

	decision_t expected_decisions [$];
	int        fail_count;

	task automatic judge_attempt(input logic [STAMP_W-1:0] now, output decision_t d);
		int                 limit;
		int                 slot;
		logic [STAMP_W-1:0] age;
		d.verdict     = VERDICT_ACCEPT;
		d.wait_frames = '0;
		limit = int'(cfg.max_messages);
		if (limit == 0)
			return;
		if (limit > RING_DEPTH)
			limit = RING_DEPTH;
		if (now < lock_end) begin
			d.verdict     = VERDICT_LOCKED;
			d.wait_frames = lock_end - now;
			return;
		end
		// window test only once enough stamps exist
		if (stamp_fill >= limit) begin
			slot = (int'(next_slot) + RING_DEPTH - limit) % RING_DEPTH;
			age  = now - stamps[slot];
			if (age < STAMP_W'(cfg.window_frames)) begin
				lock_end      = now + STAMP_W'(cfg.lock_frames);
				d.verdict     = VERDICT_FLOOD;
				d.wait_frames = lock_end - now;
				return;
			end
		end
		stamps[next_slot] = now;
		next_slot = PTR_W'((int'(next_slot) + 1) % RING_DEPTH);
		if (stamp_fill < RING_DEPTH)
			stamp_fill++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		decision_t want;
		decision_t got;
		if (!arst_n) begin
			cfg.max_messages  = MAX_MESSAGES_RST;
			cfg.window_frames = WINDOW_FRAMES_RST;
			cfg.lock_frames   = LOCK_FRAMES_RST;
			for (int k = 0; k < RING_DEPTH; k++)
				stamps[k] = '0;
			next_slot  = '0;
			stamp_fill = 0;
			lock_end   = '0;
			expected_decisions.delete();
			fail_count = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:2]))
					REG_MAX_MESSAGES:  cfg.max_messages  = pwdata[MAX_W-1:0];
					REG_WINDOW_FRAMES: cfg.window_frames = pwdata[WIN_W-1:0];
					REG_LOCK_FRAMES:   cfg.lock_frames   = pwdata[LOCK_W-1:0];
					default: ;
				endcase
			end
			// result side first, so a result never meets an attempt of the same edge
			if (outcome.valid && outcome.ready) begin
				got.verdict     = outcome.verdict;
				got.wait_frames = outcome.wait_frames;
				if (expected_decisions.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: verdict %0d wait_frames %0d",
							got.verdict, got.wait_frames);
				end else begin
					want = expected_decisions.pop_front();
					if (want !== got) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: expected verdict %0d wait_frames %0d, ",
								"got verdict %0d wait_frames %0d"},
								want.verdict, want.wait_frames,
								got.verdict, got.wait_frames);
					end
				end
			end
			if (attempt.valid && attempt.ready) begin
				judge_attempt(attempt.frame_now, want);
				expected_decisions.push_back(want);
			end
			mismatches  <= fail_count;
			outstanding <= expected_decisions.size();
		end
	end

endmodule

// File: test/tb_message_flood_limiter.sv
// top-level testbench for the message flood limiter: stimulus, backpressure and verdict
// depends on mfl_pkg, both channel interfaces, the block and mfl_decision_checker
module tb_message_flood_limiter;
	import mfl_pkg::*;

	// no transfer for this many cycles means the block hung
	localparam int STALL_LIMIT = 4000;
	// long receiver hold-off so the block fills and stalls its input
	localparam int HOLD_OFF    = 300;
	// cycles to let the two pipeline stages settle before a register write
	localparam int SETTLE      = 4;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	mfl_attempt_if attempt_ch ();
	mfl_result_if  result_ch ();

	int                 mismatch_count;
	int                 outstanding;
	int                 quiet_cycles;
	logic               calm;
	logic               pressure_go;
	logic [STAMP_W-1:0] frame_clock;

	message_flood_limiter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.attempt (attempt_ch),
		.outcome (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mfl_decision_checker decision_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.attempt     (attempt_ch),
		.outcome     (result_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatch_count),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// idle lengths: mostly from the shortest range, now and then from the longest
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 19);
		if (r < 16)
			return $urandom_range(1, 3);
		else if (r < 19)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// one attempt transfer; valid stays high into the next attempt unless a gap follows
	task automatic send_attempt(input logic [STAMP_W-1:0] frame);
		attempt_ch.valid     <= 1'b1;
		attempt_ch.frame_now <= frame;
		@(posedge clk);
		while (!attempt_ch.ready)
			@(posedge clk);
		if (!calm && $urandom_range(0, 2) == 0) begin
			// idle with junk on the payload
			attempt_ch.valid     <= 1'b0;
			attempt_ch.frame_now <= $urandom();
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// setup phase, access phase, then an idle phase before the next write
	task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// stop offering, wait for every pending decision, then let the pipeline drain
	task automatic wait_idle();
		attempt_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_config(input logic [MAX_W-1:0] limit, input logic [WIN_W-1:0] window,
			input logic [LOCK_W-1:0] lock);
		wait_idle();
		apb_write(REG_MAX_MESSAGES, DATA_W'(limit));
		apb_write(REG_WINDOW_FRAMES, DATA_W'(window));
		apb_write(REG_LOCK_FRAMES, DATA_W'(lock));
	endtask

	// result side: random stalls, calm stretches, and one long hold-off on request
	initial begin : receiver
		bit pressure_done;
		pressure_done = 1'b0;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (pressure_go && !pressure_done) begin
				pressure_done = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else if (calm || $urandom_range(0, 3) != 0) begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				result_ch.ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end
		end
	end

	// watchdog: any transfer on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (attempt_ch.valid && attempt_ch.ready) ||
				(result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_message_flood_limiter: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		int               phase;
		int               n;
		int               r;
		logic [MAX_W-1:0] lim;
		logic [WIN_W-1:0] win;
		logic [LOCK_W-1:0] lk;

		attempt_ch.valid     <= 1'b0;
		attempt_ch.frame_now <= '0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		calm        <= 1'b0;
		pressure_go <= 1'b0;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: fill four stamps, flood, lockout, lockout end, frame going backwards
		send_attempt(32'd0);
		send_attempt(32'd1);
		send_attempt(32'd2);
		send_attempt(32'd3);
		send_attempt(32'd4);
		send_attempt(32'd50);
		send_attempt(32'd104);
		send_attempt(32'd0);

		// limit zero: everything passes, extremes of frame and window and lock
		set_config(5'd0, 16'hFFFF, 16'hFFFF);
		send_attempt(32'hFFFF_FFFF);
		send_attempt(32'd0);

		// zero window never floods, zero lock
		set_config(5'd1, 16'd0, 16'd0);
		send_attempt(32'd200);
		send_attempt(32'd200);

		// limit above ring depth saturates; fill the ring, then flood with a zero lockout
		set_config(5'd31, 16'hFFFF, 16'd0);
		for (n = 0; n < 11; n++)
			send_attempt(32'd300 + n);

		// lockout end wrapping past the top of the frame counter
		set_config(5'd2, 16'hFFFF, 16'hFFFF);
		send_attempt(32'hFFFF_FFF0);
		send_attempt(32'hFFFF_FFF1);
		send_attempt(32'hFFFF_FFF2);
		send_attempt(32'd5);

		frame_clock = $urandom();
		for (phase = 0; phase < 10; phase++) begin
			r = $urandom_range(0, 19);
			if (r < 2)
				lim = 5'd0;
			else if (r < 4)
				lim = 5'd16;
			else if (r == 4)
				lim = MAX_W'($urandom_range(17, 31));
			else
				lim = MAX_W'($urandom_range(1, 15));
			r = $urandom_range(0, 9);
			if (r == 0)
				win = '0;
			else if (r == 1)
				win = '1;
			else if (r == 2)
				win = WIN_W'($urandom());
			else
				win = WIN_W'($urandom_range(1, 64));
			r = $urandom_range(0, 9);
			if (r == 0)
				lk = '0;
			else if (r == 1)
				lk = '1;
			else if (r == 2)
				lk = LOCK_W'($urandom());
			else
				lk = LOCK_W'($urandom_range(1, 200));
			// phase two runs gap-free and carries the long hold-off
			calm <= (phase == 2) || ($urandom_range(0, 4) == 0);
			set_config(lim, win, lk);
			for (n = 0; n < 138; n++) begin
				if (phase == 2 && n == 20)
					pressure_go <= 1'b1;
				// mostly a steadily advancing frame counter, some jumps and rewinds
				r = $urandom_range(0, 99);
				if (r < 70)
					frame_clock = frame_clock + $urandom_range(0, 6);
				else if (r < 85)
					frame_clock = frame_clock + $urandom_range(0, 200);
				else if (r < 92)
					frame_clock = $urandom();
				else if (r < 97)
					frame_clock = frame_clock - $urandom_range(1, 50);
				else
					frame_clock = 32'hFFFF_FFFF - $urandom_range(0, 300);
				send_attempt(frame_clock);
			end
		end

		wait_idle();
		if (mismatch_count == 0 && outstanding == 0)
			$display("tb_message_flood_limiter: done, clean");
		else
			$display("tb_message_flood_limiter: done, errors");
		$finish;
	end

endmodule
